[hw/rtl/csem_pkg.sv]
package csem_pkg;

	typedef enum logic [1:0] {
		FUNC_WAIT       = 2'd0,
		FUNC_SIGNAL     = 2'd1,
		FUNC_SIGNAL_ALL = 2'd2,
		FUNC_SIGNAL_ONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_NOT_WAITING = 3'd2,
		ST_TIMED_OUT   = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} status_t;

	localparam int unsigned InBits  = 56;
	localparam int unsigned OutBits = 32;

	// One classified request as it crosses from the front to the back part.
	typedef struct packed {
		func_t       func;
		logic [3:0]  sem_id;
		logic        sem_ok;
		logic        pair_signal;
		logic [3:0]  pair_sem_id;
		logic        pair_sem_ok;
		logic        prepost;
		logic        poll_only;
		logic [15:0] waiter_id;
		logic        target_given;
		logic        target_ok;
		logic [15:0] target_waiter;
	} req_t;

endpackage

[hw/rtl/counting_semaphore_wait_queue.sv]
// Channel  Dir  Payload
// s_axis   in   tdata[55:0]: request fields, func in the lowest bits
// m_axis   out  tdata[31:0]: status, blocked, woken_valid, woken_waiter, woken_sem; tlast
//
// Each word passes a two-entry queue into a sequencer that takes one request at a time.
// A plain request passes the sequencer's take, execute and final-word states; a wake adds
// a read and a wake state, each shifted entry a read and a write, and a targeted search a
// read and a check per entry inspected, all on the single wait-queue memory port. Reset
// clears counts and queue lengths at once; queue entries are never read before written.
// A stalled result stops only the sequencer.
module counting_semaphore_wait_queue import csem_pkg::*; #(
	parameter int unsigned NUM_SEMAPHORES = 16,
	parameter int unsigned WAIT_DEPTH     = 16,
	parameter int unsigned COUNT_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func, sem_id, sem_ok, pair_signal, pair_sem_id, pair_sem_ok, prepost,
	// poll_only, waiter_id, target_given, target_ok, target_waiter, zero pad
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, blocked, woken_valid, woken_waiter, woken_sem, zero pad
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	logic q_valid, q_ready;
	req_t q_req;

	csem_front #(.NUM_SEMAPHORES(NUM_SEMAPHORES)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.q_valid, .q_ready, .q_req
	);

	csem_back #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES), .WAIT_DEPTH(WAIT_DEPTH), .COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(m_axis_tlast)
	);

endmodule

[hw/rtl/csem_front.sv]
module csem_front import csem_pkg::*; #(
	parameter int unsigned NUM_SEMAPHORES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [InBits-1:0]   in_data,
	output logic                q_valid,
	input  logic                q_ready,
	output req_t                q_req
);

	// Two-entry queue; the front checks the index range while unpacking.
	req_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	req_t        r;

	always_comb begin
		r.func          = func_t'(in_data[1:0]);
		r.sem_id        = in_data[5:2];
		r.sem_ok        = in_data[6] && ({28'd0, in_data[5:2]} < NUM_SEMAPHORES);
		r.pair_signal   = in_data[7];
		r.pair_sem_id   = in_data[11:8];
		r.pair_sem_ok   = in_data[12] && ({28'd0, in_data[11:8]} < NUM_SEMAPHORES);
		r.prepost       = in_data[13];
		r.poll_only     = in_data[14];
		r.waiter_id     = in_data[30:15];
		r.target_given  = in_data[31];
		r.target_ok     = in_data[32];
		r.target_waiter = in_data[48:33];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wr_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_valid && q_ready) ? 1 : 0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("front queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !(q_valid && q_ready)) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !in_valid) |=> cnt_q == 2'd0)
		else $error("empty queue gained an entry");

endmodule

[hw/rtl/csem_back.sv]
module csem_back import csem_pkg::*; #(
	parameter int unsigned NUM_SEMAPHORES = 16,
	parameter int unsigned WAIT_DEPTH     = 16,
	parameter int unsigned COUNT_BITS     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  req_t                q_req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OutBits-1:0]  out_data,
	output logic                out_last
);

	localparam int unsigned SB = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int unsigned PB = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int unsigned LB = $clog2(WAIT_DEPTH + 1);
	localparam int unsigned MB = SB + PB;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_EXEC  = 9'b000000010,
		S_RDW   = 9'b000000100,
		S_WAKE  = 9'b000001000,
		S_SHRD  = 9'b000010000,
		S_SHWR  = 9'b000100000,
		S_SCAN  = 9'b001000000,
		S_SCHK  = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [COUNT_BITS-1:0] cnt_q [NUM_SEMAPHORES];
	logic [LB-1:0]         len_q [NUM_SEMAPHORES];
	logic [15:0]           ent_mem [1 << MB];
	logic [15:0]           rd_q;
	req_t                  req_q;
	logic [SB-1:0]         ws_q;      // semaphore being walked
	logic [LB-1:0]         pos_q;     // entry position
	logic [2:0]            st_q;
	logic                  blk_q, all_q;
	logic                  ov_q, olast_q;
	logic [OutBits-1:0]    od_q;

	logic                  mem_re, mem_we;
	logic [MB-1:0]         ra, wa;
	logic [15:0]           wd;
	logic [SB-1:0]         s, ps;
	logic [LB-1:0]         n, pos_n;
	logic                  out_free, emit;

	// Decisions taken in the execute state.
	logic [2:0]            x_st;
	logic                  x_blk, x_all, x_dec, x_clr, x_inc, x_push;
	logic [SB-1:0]         x_ws, x_inc_s;
	state_t                x_next;

	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	assign s  = req_q.sem_id[SB-1:0];
	assign ps = req_q.pair_sem_id[SB-1:0];
	assign n  = len_q[ws_q];
	assign pos_n = pos_q + LB'(1);
	assign out_free = !ov_q || out_ready;
	assign emit = out_free && (state_q == S_WAKE || state_q == S_FIN);
	assign q_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = olast_q;

	always_comb begin
		x_st = ST_OK; x_blk = 1'b0; x_all = 1'b0; x_dec = 1'b0; x_clr = 1'b0;
		x_inc = 1'b0; x_push = 1'b0; x_ws = s; x_inc_s = s; x_next = S_FIN;
		if (!req_q.sem_ok) x_st = ST_INVALID;
		else unique case (req_q.func)
			FUNC_WAIT: begin
				if (req_q.pair_signal && !req_q.pair_sem_ok) x_st = ST_INVALID;
				else begin
					// A take paired back onto the same empty queue leaves the count as it is.
					if (cnt_q[s] != '0)
						x_dec = !(req_q.pair_signal && ps == s && len_q[s] == '0);
					else if (req_q.poll_only) x_st = ST_TIMED_OUT;
					else if (len_q[s] >= LB'(WAIT_DEPTH)) x_st = ST_QUEUE_FULL;
					else begin
						x_push = 1'b1; x_blk = 1'b1;
					end
					if (x_st == ST_OK && req_q.pair_signal) begin
						x_ws = ps; x_inc_s = ps;
						if (len_q[ps] != '0 || (x_push && ps == s)) x_next = S_RDW;
						else if (cnt_q[ps] != CMAX && ps != s) x_inc = 1'b1;
					end
				end
			end
			FUNC_SIGNAL: begin
				if (len_q[s] != '0) x_next = S_RDW;
				else if (req_q.prepost && cnt_q[s] != CMAX) x_inc = 1'b1;
			end
			FUNC_SIGNAL_ALL: begin
				x_clr = 1'b1; x_all = 1'b1;
				if (len_q[s] != '0) x_next = S_RDW;
			end
			FUNC_SIGNAL_ONE: begin
				if (req_q.target_given && !req_q.target_ok) x_st = ST_INVALID;
				else if (len_q[s] == '0) x_st = ST_NOT_WAITING;
				else if (!req_q.target_given) x_next = S_RDW;
				else x_next = S_SCAN;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_re = 1'b0; ra = '0; mem_we = 1'b0; wa = '0; wd = req_q.waiter_id;
		unique case (state_q)
			S_RDW, S_SCAN: begin
				mem_re = 1'b1; ra = {ws_q, pos_q[PB-1:0]};
			end
			S_SHRD: begin
				mem_re = 1'b1; ra = {ws_q, pos_n[PB-1:0]};
			end
			S_SHWR: begin
				mem_we = 1'b1; wa = {ws_q, pos_q[PB-1:0]}; wd = rd_q;
			end
			S_EXEC: begin
				mem_we = x_push; wa = {s, len_q[s][PB-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_q <= ent_mem[ra];
		if (mem_we) ent_mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) req_q <= q_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NUM_SEMAPHORES; i++) begin
				cnt_q[i] <= '0;
				len_q[i] <= '0;
			end
			ws_q <= '0; pos_q <= '0; st_q <= ST_OK; blk_q <= 1'b0; all_q <= 1'b0;
			ov_q <= 1'b0; olast_q <= 1'b0; od_q <= '0;
		end else begin
			ov_q <= (ov_q && !out_ready) || emit;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_EXEC;
				S_EXEC: begin
					st_q <= x_st; blk_q <= x_blk; all_q <= x_all; pos_q <= '0; ws_q <= x_ws;
					state_q <= x_next;
					if (x_dec) cnt_q[s] <= cnt_q[s] - 1'b1;
					else if (x_clr) cnt_q[s] <= '0;
					if (x_inc) cnt_q[x_inc_s] <= cnt_q[x_inc_s] + 1'b1;
					if (x_push) len_q[s] <= len_q[s] + LB'(1);
				end
				S_RDW: state_q <= S_WAKE;
				S_WAKE: if (out_free) begin
					olast_q <= 1'b0;
					od_q <= OutBits'({4'(ws_q), rd_q, 1'b1, 1'b0, ST_OK});
					if (pos_n < n) state_q <= S_SHRD;
					else begin
						len_q[ws_q] <= n - LB'(1);
						pos_q <= '0;
						if (all_q && n > LB'(1)) state_q <= S_RDW;
						else state_q <= S_FIN;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (pos_n + LB'(1) < n) begin
						pos_q <= pos_n;
						state_q <= S_SHRD;
					end else begin
						len_q[ws_q] <= n - LB'(1);
						pos_q <= '0;
						if (all_q && n > LB'(1)) state_q <= S_RDW;
						else state_q <= S_FIN;
					end
				end
				S_SCAN: state_q <= S_SCHK;
				S_SCHK: begin
					if (rd_q == req_q.target_waiter) state_q <= S_RDW;
					else if (pos_n < n) begin pos_q <= pos_n; state_q <= S_SCAN; end
					else begin st_q <= ST_NOT_WAITING; state_q <= S_FIN; end
				end
				S_FIN: if (out_free) begin
					olast_q <= 1'b1;
					od_q <= OutBits'({blk_q, st_q});
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> (ov_q && $stable(od_q)))
		else $error("result overwritten while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAKE) |-> (n != '0))
		else $error("wake from an empty queue");

endmodule
